[sv/bdqs_pkg.sv]
// Shared types for the bounded deque with search: command and result
// structs, operation and status codes, sequencer states. No dependencies.
`timescale 1ns / 1ps

package bdqs_pkg;

  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_SEARCH     = 3'd4,
    OP_READ_IDX   = 3'd5,
    OP_CLEAR      = 3'd6
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_OOB   = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_READ   = 3'b010,
    S_SEARCH = 3'b100
  } state_e;

  localparam int unsigned ValueW = 32;
  localparam int unsigned CountW = 5;

  typedef struct packed {
    op_e               kind;
    logic [ValueW-1:0] value;
    logic [3:0]        position;
  } cmd_t;

  typedef struct packed {
    logic [ValueW-1:0] data_out;
    logic              found;
    logic [CountW-1:0] count;
    status_e           status;
  } res_t;

endpackage

[sv/bdqs_store.sv]
// Ring buffer storage: one write and one registered read port, each
// addressed as an offset from the front pointer. No package dependency.
`timescale 1ns / 1ps

module bdqs_store #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                       clk_i,
  input  logic [$clog2(DEPTH)-1:0]   base_i,
  input  logic                       wr_en_i,
  input  logic [$clog2(DEPTH)-1:0]   wr_off_i,
  input  logic [DATA_WIDTH-1:0]      wr_data_i,
  input  logic [$clog2(DEPTH)-1:0]   rd_off_i,
  output logic [DATA_WIDTH-1:0]      rd_data_o
);

  localparam int unsigned AW = $clog2(DEPTH);

  logic [DATA_WIDTH-1:0] mem_q [DEPTH];
  logic [DATA_WIDTH-1:0] rd_data_q;
  logic [AW-1:0]         wr_addr;
  logic [AW-1:0]         rd_addr;

  // base + offset, folded back into the ring with one compare and subtract
  function automatic logic [AW-1:0] wrap(input logic [AW-1:0] b, input logic [AW-1:0] o);
    logic [AW:0] s;
    s = {1'b0, b} + {1'b0, o};
    if (s >= (AW+1)'(DEPTH)) begin
      s = s - (AW+1)'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  assign wr_addr = wrap(base_i, wr_off_i);
  assign rd_addr = wrap(base_i, rd_off_i);

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_q <= mem_q[rd_addr];
  end

  assign rd_data_o = rd_data_q;

endmodule

[sv/bounded_deque_with_search_top.sv]
// Bounded deque with search. Push, clear and error results are strobed in the
// cycle after the transfer; pops and indexed reads go through the registered
// store read and S_READ; search steps the single compare through the store one
// entry per cycle, up to a hit or the last entry. busy is low again in the
// cycle the result is strobed, so the next transfer may follow at once.
// Reset clears count, front pointer and sequencer; store contents are left as is.
`timescale 1ns / 1ps

module bounded_deque_with_search_top
  import bdqs_pkg::*;
#(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  cmd_t cmd_i,
  output logic done_o,
  output res_t res_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned VW = (DATA_WIDTH < ValueW) ? DATA_WIDTH : ValueW;

  state_e                state_q, state_d;
  logic [AW-1:0]         fp_q, fp_d;
  logic [CW-1:0]         count_q, count_d;
  logic [AW-1:0]         idx_q, idx_d;
  logic [DATA_WIDTH-1:0] value_q, value_d;
  logic                  done_q, done_d;
  res_t                  res_q, res_d;

  logic                  accept;
  logic                  full;
  logic                  empty;
  logic [AW-1:0]         fp_inc;
  logic [AW-1:0]         fp_dec;
  logic                  wr_en;
  logic [AW-1:0]         wr_off;
  logic [DATA_WIDTH-1:0] wr_data;
  logic [AW-1:0]         rd_off;
  logic [DATA_WIDTH-1:0] rd_data;
  logic                  hit;
  logic                  last;

  assign busy   = (state_q != S_IDLE);
  assign accept = start && !busy;
  assign full   = (count_q == CW'(DEPTH));
  assign empty  = (count_q == '0);
  assign fp_inc = (fp_q == AW'(DEPTH - 1)) ? '0 : fp_q + 1'b1;
  assign fp_dec = (fp_q == '0) ? AW'(DEPTH - 1) : fp_q - 1'b1;
  assign wr_data = DATA_WIDTH'(cmd_i.value[VW-1:0]);
  assign hit    = (rd_data == value_q);
  assign last   = ((CW'(idx_q) + 1'b1) == count_q);

  bdqs_store #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_store (
    .clk_i     (clk_i),
    .base_i    (fp_q),
    .wr_en_i   (wr_en),
    .wr_off_i  (wr_off),
    .wr_data_i (wr_data),
    .rd_off_i  (rd_off),
    .rd_data_o (rd_data)
  );

  always_comb begin
    state_d = state_q;
    fp_d    = fp_q;
    count_d = count_q;
    idx_d   = idx_q;
    value_d = value_q;
    done_d  = 1'b0;
    res_d   = res_q;
    wr_en   = 1'b0;
    wr_off  = '0;
    rd_off  = '0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          value_d = wr_data;
          res_d   = '0;
          unique case (cmd_i.kind)
            OP_PUSH_FRONT: begin
              done_d = 1'b1;
              if (full) begin
                res_d.status = ST_FULL;
              end else begin
                wr_en   = 1'b1;
                wr_off  = AW'(DEPTH - 1);
                fp_d    = fp_dec;
                count_d = count_q + 1'b1;
              end
            end
            OP_PUSH_BACK: begin
              done_d = 1'b1;
              if (full) begin
                res_d.status = ST_FULL;
              end else begin
                wr_en   = 1'b1;
                wr_off  = AW'(count_q);
                count_d = count_q + 1'b1;
              end
            end
            OP_POP_FRONT: begin
              if (empty) begin
                done_d       = 1'b1;
                res_d.status = ST_EMPTY;
              end else begin
                rd_off  = '0;
                fp_d    = fp_inc;
                count_d = count_q - 1'b1;
                state_d = S_READ;
              end
            end
            OP_POP_BACK: begin
              if (empty) begin
                done_d       = 1'b1;
                res_d.status = ST_EMPTY;
              end else begin
                rd_off  = AW'(count_q - 1'b1);
                count_d = count_q - 1'b1;
                state_d = S_READ;
              end
            end
            OP_SEARCH: begin
              if (empty) begin
                done_d = 1'b1;
              end else begin
                idx_d   = '0;
                rd_off  = '0;
                state_d = S_SEARCH;
              end
            end
            OP_READ_IDX: begin
              if (32'(cmd_i.position) >= 32'(count_q)) begin
                done_d       = 1'b1;
                res_d.status = ST_OOB;
              end else begin
                rd_off  = AW'(cmd_i.position);
                state_d = S_READ;
              end
            end
            OP_CLEAR: begin
              done_d  = 1'b1;
              count_d = '0;
              fp_d    = '0;
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end
      S_READ: begin
        res_d          = '0;
        res_d.data_out = ValueW'(rd_data);
        done_d         = 1'b1;
        state_d        = S_IDLE;
      end
      S_SEARCH: begin
        // fetch the next entry while comparing the current one
        rd_off = idx_q + 1'b1;
        if (hit || last) begin
          res_d       = '0;
          res_d.found = hit;
          done_d      = 1'b1;
          state_d     = S_IDLE;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    res_d.count = CountW'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      fp_q    <= '0;
      count_q <= '0;
      idx_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      fp_q    <= fp_d;
      count_q <= count_d;
      idx_q   <= idx_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    res_q   <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("entry count exceeds depth");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobed while sequencer busy");

  a_read_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_READ |=> done_o)
    else $error("store read did not complete in one cycle");

  a_full_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && full && (cmd_i.kind == OP_PUSH_FRONT || cmd_i.kind == OP_PUSH_BACK)
    |=> done_o && res_o.status == ST_FULL && $stable(count_q))
    else $error("push on full queue not dropped");

endmodule

[verif/bdqs_checker.sv]
// Checker for the bounded deque with search: watches the command and result
// channels, keeps a shadow deque and compares every result in order.
// Depends on bdqs_pkg for the command and result structs and the codes.
`timescale 1ns / 1ps

module bdqs_checker
  import bdqs_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  cmd_t        cmd_i,
  input  logic        done_i,
  input  res_t        res_i,
  output int unsigned mismatches_o,
  output int unsigned pending_o,
  output int unsigned checked_o
);

  localparam int unsigned FrontW = $clog2(DEPTH);

  logic [ValueW-1:0] shadow_store [DEPTH];
  logic [FrontW-1:0] shadow_front;
  logic [CountW-1:0] shadow_count;
  res_t              predicted_res_q [$];
  res_t              want;
  int unsigned       n_mismatch;
  int unsigned       n_checked;

  function automatic int ring_idx(int offset);
    return (int'(shadow_front) + offset) % DEPTH;
  endfunction

  function automatic string res_str(res_t r);
    return $sformatf("data %h found %0d count %0d status %0d",
                     r.data_out, r.found, r.count, r.status);
  endfunction

  // Apply one operation to the shadow deque and return what the block should give.
  function automatic res_t apply_deque_op(cmd_t c);
    res_t r;
    r = '0;
    case (c.kind) inside
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (shadow_count >= CountW'(DEPTH)) begin
          r.status = ST_FULL;
        end else if (c.kind == OP_PUSH_FRONT) begin
          shadow_front = FrontW'(ring_idx(DEPTH - 1));
          shadow_store[shadow_front] = c.value;
          shadow_count = shadow_count + 1'b1;
        end else begin
          shadow_store[ring_idx(int'(shadow_count))] = c.value;
          shadow_count = shadow_count + 1'b1;
        end
      end
      OP_POP_FRONT: begin
        if (shadow_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.data_out   = shadow_store[shadow_front];
          shadow_front = FrontW'(ring_idx(1));
          shadow_count = shadow_count - 1'b1;
        end
      end
      OP_POP_BACK: begin
        if (shadow_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.data_out   = shadow_store[ring_idx(int'(shadow_count) - 1)];
          shadow_count = shadow_count - 1'b1;
        end
      end
      OP_SEARCH: begin
        for (int i = 0; i < int'(shadow_count) && !r.found; i++) begin
          if (shadow_store[ring_idx(i)] == c.value) r.found = 1'b1;
        end
      end
      OP_READ_IDX: begin
        if (CountW'(c.position) >= shadow_count) begin
          r.status = ST_OOB;
        end else begin
          r.data_out = shadow_store[ring_idx(int'(c.position))];
        end
      end
      OP_CLEAR: begin
        shadow_count = '0;
        shadow_front = '0;
      end
      default: ;
    endcase
    r.count = shadow_count;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      predicted_res_q.delete();
      shadow_front = '0;
      shadow_count = '0;
      n_mismatch   = 0;
      n_checked    = 0;
    end else begin
      // Compare first: a result strobed now belongs to an earlier transfer.
      if (done_i) begin
        if (predicted_res_q.size() == 0) begin
          n_mismatch++;
          if (n_mismatch <= 10) begin
            $display("%0t: result with nothing outstanding: %s", $realtime, res_str(res_i));
          end
        end else begin
          want = predicted_res_q.pop_front();
          n_checked++;
          if (res_i.data_out !== want.data_out || res_i.found !== want.found ||
              res_i.count !== want.count || res_i.status !== want.status) begin
            n_mismatch++;
            if (n_mismatch <= 10) begin
              $display("%0t: mismatch: expected %s", $realtime, res_str(want));
              $display("%0t:           got      %s", $realtime, res_str(res_i));
            end
          end
        end
      end
      if (start_i && !busy_i) begin
        predicted_res_q.push_back(apply_deque_op(cmd_i));
      end
    end
    mismatches_o <= n_mismatch;
    pending_o    <= predicted_res_q.size();
    checked_o    <= n_checked;
  end

endmodule

[verif/tb.sv]
// Testbench top for the bounded deque with search: clock, reset, directed and
// random command stream, verdict. Depends on bdqs_pkg, bdqs_checker and the block.
`timescale 1ns / 1ps

module tb;
  import bdqs_pkg::*;

  localparam int unsigned Depth      = 16;
  localparam int unsigned NumRandom  = 2000;
  localparam int unsigned CalmTail   = 200;
  localparam int unsigned CycleLimit = 400000;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  cmd_t        cmd;
  logic        done;
  res_t        res;
  int unsigned mismatches;
  int unsigned pending;
  int unsigned checked;
  int unsigned cycle_cnt = 0;
  int unsigned sent = 0;
  bit          calm_tail = 1'b0;
  logic [31:0] value_pool [8];

  bounded_deque_with_search_top #(
    .DEPTH      (Depth),
    .DATA_WIDTH (32)
  ) i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .start  (start),
    .busy   (busy),
    .cmd_i  (cmd),
    .done_o (done),
    .res_o  (res)
  );

  bdqs_checker #(
    .DEPTH (Depth)
  ) i_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .start_i      (start),
    .busy_i       (busy),
    .cmd_i        (cmd),
    .done_i       (done),
    .res_i        (res),
    .mismatches_o (mismatches),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt, pending);
      $display("status: fail");
      $finish;
    end
  end

  // Hold the command until the transfer, then maybe drop start for a random pause.
  task automatic issue(op_e kind, logic [31:0] value, logic [3:0] position);
    cmd_t c;
    c.kind     = kind;
    c.value    = value;
    c.position = position;
    cmd   <= c;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    sent++;
    if (!calm_tail && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  // Mode 0 fills the deque, mode 1 drains it, mode 2 mixes everything.
  function automatic op_e pick_op(int mode);
    int r;
    r = $urandom_range(0, 99);
    if (mode == 0 && r < 85) begin
      return r[0] ? OP_PUSH_BACK : OP_PUSH_FRONT;
    end else if (mode == 1 && r < 85) begin
      return r[0] ? OP_POP_BACK : OP_POP_FRONT;
    end else if (r < 3) begin
      return OP_CLEAR;
    end
    return op_e'(3'($urandom_range(0, 5)));
  endfunction

  function automatic logic [31:0] pick_value();
    if ($urandom_range(0, 1) == 0) return value_pool[$urandom_range(0, 7)];
    return $urandom();
  endfunction

  initial begin
    int mode;
    int burst;
    rst_n = 1'b0;
    start = 1'b0;
    cmd   = '0;
    value_pool[0] = 32'h0000_0000;
    value_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < 8; i++) value_pool[i] = $urandom();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty deque: pops report empty, any read is out of bounds, search misses.
    issue(OP_CLEAR, 32'h0, 4'd0);
    issue(OP_POP_FRONT, 32'h0, 4'd0);
    issue(OP_POP_BACK, 32'h0, 4'd0);
    issue(OP_READ_IDX, 32'h0, 4'd0);
    issue(OP_SEARCH, 32'h0, 4'd0);
    issue(OP_PUSH_BACK, 32'h0000_0000, 4'd15);
    issue(OP_PUSH_FRONT, 32'hFFFF_FFFF, 4'd0);
    issue(OP_PUSH_BACK, 32'h8000_0001, 4'd0);
    issue(OP_PUSH_FRONT, 32'h7FFE_FFFE, 4'd0);
    issue(OP_READ_IDX, 32'h0, 4'd0);
    issue(OP_READ_IDX, 32'h0, 4'd3);
    issue(OP_READ_IDX, 32'h0, 4'd4);
    issue(OP_READ_IDX, 32'h0, 4'd15);
    issue(OP_SEARCH, 32'hFFFF_FFFF, 4'd0);
    issue(OP_SEARCH, 32'h8000_0001, 4'd0);
    issue(OP_SEARCH, 32'h1234_5678, 4'd0);
    issue(OP_POP_BACK, 32'h0, 4'd0);
    issue(OP_POP_FRONT, 32'h0, 4'd0);
    issue(OP_CLEAR, 32'h0, 4'd0);
    issue(OP_POP_FRONT, 32'h0, 4'd0);
    issue(OP_READ_IDX, 32'h0, 4'd0);

    // Random bursts; fill bursts of up to 40 commands can reach full from empty.
    while (sent < NumRandom + 21) begin
      mode  = $urandom_range(0, 2);
      burst = $urandom_range(10, 40);
      for (int n = 0; n < burst; n++) begin
        if (sent + CalmTail >= NumRandom + 21) calm_tail = 1'b1;
        issue(pick_op(mode), pick_value(), 4'($urandom_range(0, 15)));
      end
    end

    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (Depth + 4) @(posedge clk);
    $display("covered %0d commands (directed and random fill, drain and mixed bursts)", sent);
    $display("checked %0d results, %0d mismatched", checked, mismatches);
    if (mismatches == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
